// ===== design/leb_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// leb_pkg
// Shared types and constants for the line edit buffer.
// ----------------------------------------------------------------------------
package leb_pkg;

    localparam int CHAR_W = 8;
    localparam int REG_IDX_W = 2;

    localparam logic [REG_IDX_W-1:0] REG_ERASE    = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_KILL     = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_LINE_END = 2'd2;

    localparam logic [CHAR_W-1:0] ERASE_RST    = 8'd35;
    localparam logic [CHAR_W-1:0] KILL_RST     = 8'd64;
    localparam logic [CHAR_W-1:0] LINE_END_RST = 8'd10;

    localparam logic OP_CHAR  = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    typedef struct packed {
        logic char_acc;
        logic kill_pop;
        logic rd_flush;
        logic flush_start;
        logic flush_step;
        logic load_char;
        logic load_empty;
        logic flush_end;
    } leb_cmd_t;

    typedef struct packed {
        logic is_kill;
        logic cnt_zero;
        logic top_le;
        logic ptr_last;
        logic out_free;
    } leb_sts_t;

endpackage

`default_nettype wire

// ===== design/line_edit_buffer.sv =====
`default_nettype none
// Character and erase transfers are handled in the idle state; a kill repeats a store
//   read and line-end check per removed character until empty or a line end stops it.
// A flush emits each character by a store read, then an output register load that waits while
//   the output is held; an empty flush gives one result. No transfer is accepted until it ends.
// Reset (aresetn, synchronous): clears fill count, overflow flag and output
//   valid, and restores the edit characters to their defaults.
// ----------------------------------------------------------------------------
// line_edit_buffer
// Stack-based line edit buffer with erase, kill and flush.
// ----------------------------------------------------------------------------
module line_edit_buffer #(
    parameter int DEPTH = 64
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_we,
    input  wire logic [leb_pkg::REG_IDX_W-1:0] cfg_addr,
    input  wire logic [leb_pkg::CHAR_W-1:0]    cfg_wdata,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [leb_pkg::CHAR_W-1:0]    s_tdata,   // [7:0] char_in
    input  wire logic [0:0]                    s_tuser,   // [0] op
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [leb_pkg::CHAR_W-1:0]         m_tdata,   // [7:0] char_out
    output logic                               m_tlast,
    output logic [1:0]                         m_tuser    // [0] was_empty, [1] overflowed
);
    import leb_pkg::*;

    leb_cmd_t cmd;
    leb_sts_t sts;

    leb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .op       (s_tuser[0]),
        .sts      (sts),
        .cmd      (cmd)
    );

    leb_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .char_in   (s_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

// ===== design/leb_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// leb_ctrl
// Sequencer for character, kill and flush transfers.
// ----------------------------------------------------------------------------
module leb_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic              op,
    input  wire leb_pkg::leb_sts_t sts,
    output leb_pkg::leb_cmd_t      cmd
);
    import leb_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_KILL_RD  = 6'b000010,
        ST_KILL_CHK = 6'b000100,
        ST_FL_RD    = 6'b001000,
        ST_FL_OUT   = 6'b010000,
        ST_FL_EMPTY = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   acc;

    assign s_tready = (state_reg == ST_IDLE);
    assign acc      = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (acc) begin
                    if (op == OP_FLUSH) begin
                        if (sts.cnt_zero) begin
                            state_next = ST_FL_EMPTY;
                        end else begin
                            cmd.flush_start = 1'b1;
                            state_next      = ST_FL_RD;
                        end
                    end else begin
                        cmd.char_acc = 1'b1;
                        if (sts.is_kill) begin
                            state_next = ST_KILL_RD;
                        end
                    end
                end
            end
            ST_KILL_RD: begin
                state_next = sts.cnt_zero ? ST_IDLE : ST_KILL_CHK;
            end
            ST_KILL_CHK: begin
                if (sts.top_le) begin
                    state_next = ST_IDLE;
                end else begin
                    cmd.kill_pop = 1'b1;
                    state_next   = ST_KILL_RD;
                end
            end
            ST_FL_RD: begin
                cmd.rd_flush = 1'b1;
                state_next   = ST_FL_OUT;
            end
            ST_FL_OUT: begin
                cmd.rd_flush = 1'b1;
                if (sts.out_free) begin
                    cmd.load_char = 1'b1;
                    if (sts.ptr_last) begin
                        cmd.flush_end = 1'b1;
                        state_next    = ST_IDLE;
                    end else begin
                        cmd.flush_step = 1'b1;
                        state_next     = ST_FL_RD;
                    end
                end
            end
            ST_FL_EMPTY: begin
                if (sts.out_free) begin
                    cmd.load_empty = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/leb_dpath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// leb_dpath
// Character store, fill count, overflow flag, config and output register.
// ----------------------------------------------------------------------------
module leb_dpath #(
    parameter int DEPTH = 64
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_we,
    input  wire logic [leb_pkg::REG_IDX_W-1:0]   cfg_addr,
    input  wire logic [leb_pkg::CHAR_W-1:0]      cfg_wdata,
    input  wire logic [leb_pkg::CHAR_W-1:0]      char_in,
    input  wire leb_pkg::leb_cmd_t               cmd,
    output leb_pkg::leb_sts_t                    sts,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [leb_pkg::CHAR_W-1:0]           m_tdata,   // [7:0] char_out
    output logic                                 m_tlast,
    output logic [1:0]                           m_tuser    // [0] was_empty, [1] overflowed
);
    import leb_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [CHAR_W-1:0] mem [DEPTH];
    logic [CHAR_W-1:0] rd_data_reg;
    logic [AW-1:0]     rd_addr;

    logic [CHAR_W-1:0] erase_reg, kill_reg, line_end_reg;
    logic [CW-1:0]     count_reg, count_next;
    logic              ovf_reg, ovf_next;
    logic [AW-1:0]     ptr_reg, ptr_next;
    logic [CW-1:0]     top_idx;

    logic              out_valid_reg;
    logic [CHAR_W-1:0] out_char_reg;
    logic              out_last_reg, out_empty_reg, out_ovf_reg;

    logic is_erase, is_kill, full, do_push;

    assign is_erase = (char_in == erase_reg);
    assign is_kill  = !is_erase && (char_in == kill_reg);
    assign full     = (count_reg == FULL_CNT);
    assign do_push  = cmd.char_acc && !is_erase && !is_kill && !full;
    assign top_idx  = count_reg - CW'(1);
    assign rd_addr  = cmd.rd_flush ? ptr_reg : top_idx[AW-1:0];

    assign sts.is_kill  = is_kill;
    assign sts.cnt_zero = (count_reg == '0);
    assign sts.top_le   = (rd_data_reg == line_end_reg);
    assign sts.ptr_last = ((CW'(ptr_reg) + CW'(1)) == count_reg);
    assign sts.out_free = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[count_reg[AW-1:0]] <= char_in;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        ptr_next   = ptr_reg;
        if (cmd.char_acc) begin
            if (is_erase) begin
                if (count_reg != '0) begin
                    count_next = count_reg - CW'(1);
                end
            end else if (!is_kill) begin
                if (full) begin
                    ovf_next = 1'b1;
                end else begin
                    count_next = count_reg + CW'(1);
                end
            end
        end
        if (cmd.kill_pop) begin
            count_next = count_reg - CW'(1);
        end
        if (cmd.flush_start) begin
            ptr_next = '0;
        end
        if (cmd.flush_step) begin
            ptr_next = ptr_reg + AW'(1);
        end
        if (cmd.flush_end || cmd.load_empty) begin
            count_next = '0;
            ovf_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            erase_reg     <= ERASE_RST;
            kill_reg      <= KILL_RST;
            line_end_reg  <= LINE_END_RST;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_ERASE:    erase_reg    <= cfg_wdata;
                    REG_KILL:     kill_reg     <= cfg_wdata;
                    REG_LINE_END: line_end_reg <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            ptr_reg   <= ptr_next;
            if (cmd.load_char || cmd.load_empty) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_char) begin
            out_char_reg  <= rd_data_reg;
            out_last_reg  <= sts.ptr_last;
            out_empty_reg <= 1'b0;
            out_ovf_reg   <= ovf_reg;
        end else if (cmd.load_empty) begin
            out_char_reg  <= '0;
            out_last_reg  <= 1'b1;
            out_empty_reg <= 1'b1;
            out_ovf_reg   <= ovf_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_char_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = {out_ovf_reg, out_empty_reg};

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for line_edit_buffer. Edit and flush streams, directed
// first and then random, run under several edit-character settings with
// random backpressure on both sides. Every flushed character is compared
// against a behavioral model of the character stack.
// ----------------------------------------------------------------------------
module tb_top;
    import leb_pkg::*;

    localparam int DEPTH = 64;
    localparam int SETTLE_CYCLES = 2 * DEPTH + 32;
    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_CYCLES = 400;
    localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic              op;
        logic [CHAR_W-1:0] ch;
    } edit_item_t;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
        logic              empty;
        logic              ovf;
    } flush_beat_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [REG_IDX_W-1:0] cfg_addr = '0;
    logic [CHAR_W-1:0]    cfg_wdata = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [CHAR_W-1:0]    s_tdata = '0;   // [7:0] char_in
    logic [0:0]           s_tuser = '0;   // [0] op
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [CHAR_W-1:0]    m_tdata;        // [7:0] char_out
    logic                 m_tlast;
    logic [1:0]           m_tuser;        // [0] was_empty, [1] overflowed

    edit_item_t  items_pending[$];
    flush_beat_t beats_due[$];

    logic [CHAR_W-1:0] stack_mem [DEPTH];
    int                stack_fill = 0;
    logic              stack_ovf = 1'b0;
    logic [CHAR_W-1:0] erase_code = ERASE_RST;
    logic [CHAR_W-1:0] kill_code = KILL_RST;
    logic [CHAR_W-1:0] eol_code = LINE_END_RST;

    logic idle_on = 1'b1;
    logic hold_req = 1'b0;
    int   hold_cnt = 0;
    logic s_fire = 1'b0;
    int   quiet_cycles = 0;
    int   errors = 0;

    line_edit_buffer #(.DEPTH(DEPTH)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    always #10 aclk = ~aclk;

    function automatic void edit_step(edit_item_t it);
        flush_beat_t b;
        if (it.op == OP_CHAR) begin
            if (it.ch == erase_code) begin
                if (stack_fill > 0)
                    stack_fill--;
            end else if (it.ch == kill_code) begin
                while (stack_fill > 0 && stack_mem[stack_fill-1] != eol_code)
                    stack_fill--;
            end else if (stack_fill < DEPTH) begin
                stack_mem[stack_fill] = it.ch;
                stack_fill++;
            end else begin
                stack_ovf = 1'b1;
            end
        end else if (stack_fill == 0) begin
            b = '{ch: '0, last: 1'b1, empty: 1'b1, ovf: stack_ovf};
            beats_due.push_back(b);
            stack_ovf = 1'b0;
        end else begin
            for (int k = 0; k < stack_fill; k++) begin
                b = '{ch: stack_mem[k], last: (k == stack_fill - 1), empty: 1'b0,
                      ovf: stack_ovf};
                beats_due.push_back(b);
            end
            stack_fill = 0;
            stack_ovf = 1'b0;
        end
    endfunction

    // transfer checking and model update
    always @(posedge aclk) begin
        flush_beat_t want;
        if (aresetn) begin
            s_fire <= s_tvalid && s_tready;
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (m_tvalid && m_tready) begin
                if (beats_due.size() == 0) begin
                    $error("unexpected transfer: char_out %0d", m_tdata);
                    errors++;
                end else begin
                    want = beats_due.pop_front();
                    if (m_tdata !== want.ch) begin
                        $error("char_out: expected %0d, got %0d", want.ch, m_tdata);
                        errors++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, m_tlast);
                        errors++;
                    end
                    if (m_tuser[0] !== want.empty) begin
                        $error("was_empty: expected %0d, got %0d", want.empty, m_tuser[0]);
                        errors++;
                    end
                    if (m_tuser[1] !== want.ovf) begin
                        $error("overflowed: expected %0d, got %0d", want.ovf, m_tuser[1]);
                        errors++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                edit_step('{op: s_tuser[0], ch: s_tdata});
            if (cfg_we) begin
                case (cfg_addr)
                    REG_ERASE:    erase_code = cfg_wdata;
                    REG_KILL:     kill_code = cfg_wdata;
                    REG_LINE_END: eol_code = cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    // input driver
    always @(negedge aclk) begin
        edit_item_t it;
        if (aresetn && (!s_tvalid || s_fire)) begin
            if (items_pending.size() != 0 && !(idle_on && $urandom_range(99) < 13)) begin
                it = items_pending.pop_front();
                s_tdata  <= it.ch;
                s_tuser  <= it.op;
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result receiver, with one long hold-off on request
    always @(negedge aclk) begin
        if (hold_req && hold_cnt < HOLD_CYCLES) begin
            hold_cnt <= hold_cnt + 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= !(idle_on && $urandom_range(99) < 13);
        end
    end

    initial begin
        @(posedge aresetn);
        while (quiet_cycles < STALL_LIMIT)
            @(posedge aclk);
        $display("line_edit_buffer verification failed");
        $finish;
    end

    task automatic add_item(logic op, logic [CHAR_W-1:0] ch);
        items_pending.push_back('{op: op, ch: ch});
    endtask

    task automatic drain();
        @(posedge aclk);
        while (items_pending.size() != 0 || s_tvalid || beats_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [CHAR_W-1:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_codes(logic [CHAR_W-1:0] er, logic [CHAR_W-1:0] kl,
                             logic [CHAR_W-1:0] le);
        write_reg(REG_ERASE, er);
        write_reg(REG_KILL, kl);
        write_reg(REG_LINE_END, le);
        @(posedge aclk);
    endtask

    // short random edit sequences ending in a flush
    task automatic random_run(int n);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 10)
                add_item(OP_CHAR, erase_code);
            else if (r < 18)
                add_item(OP_CHAR, kill_code);
            else if (r < 30)
                add_item(OP_CHAR, eol_code);
            else if (r < 38)
                add_item(OP_FLUSH, CHAR_W'($urandom_range(255)));
            else
                add_item(OP_CHAR, CHAR_W'($urandom_range(255)));
        end
        add_item(OP_FLUSH, CHAR_W'($urandom_range(255)));
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty flush, erase and kill on empty, extremes of char_in
        add_item(OP_FLUSH, 8'd0);
        add_item(OP_CHAR, ERASE_RST);
        add_item(OP_CHAR, KILL_RST);
        add_item(OP_CHAR, 8'd0);
        add_item(OP_CHAR, 8'd255);
        add_item(OP_CHAR, "a");
        add_item(OP_FLUSH, ERASE_RST);
        // kill back to a line end, then kill with line end on top
        add_item(OP_CHAR, "a");
        add_item(OP_CHAR, "b");
        add_item(OP_CHAR, LINE_END_RST);
        add_item(OP_CHAR, "c");
        add_item(OP_CHAR, "d");
        add_item(OP_CHAR, KILL_RST);
        add_item(OP_CHAR, KILL_RST);
        add_item(OP_CHAR, LINE_END_RST);
        add_item(OP_CHAR, ERASE_RST);
        add_item(OP_CHAR, ERASE_RST);
        add_item(OP_FLUSH, 8'hAA);
        // kill with no line end stored
        add_item(OP_CHAR, "x");
        add_item(OP_CHAR, "y");
        add_item(OP_CHAR, KILL_RST);
        add_item(OP_FLUSH, KILL_RST);
        drain();

        // full buffer, dropped characters, sticky flag across a kill
        idle_on = 1'b0;
        for (int k = 0; k < DEPTH + 2; k++)
            add_item(OP_CHAR, (k == 10) ? LINE_END_RST : CHAR_W'(65 + k % 26));
        add_item(OP_CHAR, KILL_RST);
        add_item(OP_FLUSH, 8'h55);
        add_item(OP_FLUSH, 8'hFF);
        drain();

        idle_on = 1'b1;
        random_run(3);
        drain();

        set_codes(8'd0, 8'd255, 8'd128);
        random_run(3);
        drain();

        // erase and kill share a code; erase takes priority
        idle_on = 1'b0;
        set_codes(8'd255, 8'd255, 8'd0);
        write_reg(REG_UNUSED, 8'h55);
        random_run(3);
        drain();

        // kill and line end share a code; sink stalls while source keeps going
        idle_on = 1'b1;
        set_codes(8'd1, 8'd2, 8'd2);
        hold_req = 1'b1;
        repeat (4) add_item(OP_CHAR, CHAR_W'($urandom_range(255, 3)));
        add_item(OP_FLUSH, 8'h00);
        random_run(3);
        drain();

        set_codes(CHAR_W'($urandom_range(255)), CHAR_W'($urandom_range(255)),
                  CHAR_W'($urandom_range(255)));
        random_run(3);
        drain();

        if (errors == 0)
            $display("line_edit_buffer verification clean");
        else
            $display("line_edit_buffer verification failed");
        $finish;
    end

endmodule
